### rtl/ngll_pkg.sv
// shared types, constants and helper functions of the gll position parser
package ngll_pkg;

    // fraction digits kept in the fixed-point coordinate and longest numeric field
    localparam int FRAC_DIGITS = 5;
    localparam int MAX_FIELD   = 15;

    // result width fixed by the output format, magnitude is one bit less
    localparam int OUT_W = 35;
    localparam int MAG_W = OUT_W - 1;

    function automatic longint ipow(input longint base, input int n);
        longint r;
        r = 1;
        for (int i = 0; i < n; i++) begin
            r = r * base;
        end
        return r;
    endfunction

    function automatic longint pow10(input int n);
        return ipow(10, n);
    endfunction

    // accumulated coordinate, ddmm scaled by 10^FRAC_DIGITS
    localparam longint RAW_LIMIT = pow10(5 + FRAC_DIGITS) - 1;
    localparam int     RAW_W     = $clog2(RAW_LIMIT + 1);
    localparam int     THR_W     = RAW_W + 1;
    localparam int     FRAC_W    = $clog2(FRAC_DIGITS + 1);
    localparam int     SCALE_W   = $clog2(pow10(FRAC_DIGITS) + 1);

    localparam logic [RAW_W-1:0] C_RAW_LIMIT = RAW_W'(RAW_LIMIT);
    // an accumulator at or above this value saturates on the next digit
    localparam logic [RAW_W-1:0] C_DIGIT_SAT = RAW_W'(pow10(4 + FRAC_DIGITS));

    // degree split: raw / (100 * 10^FRAC_DIGITS)
    localparam longint DEG_DIV = 100 * pow10(FRAC_DIGITS);
    localparam longint DEG_MAX = RAW_LIMIT / DEG_DIV;
    localparam int     DEG_W   = $clog2(DEG_MAX + 1);
    localparam int     MIN_W   = $clog2(DEG_DIV);
    localparam int     K1      = RAW_W;
    localparam longint R1      = (longint'(1) << K1) / DEG_DIV;
    localparam int     R1_W    = $clog2(R1 + 1);
    localparam int     M1_W    = RAW_W + R1_W;

    localparam logic [MIN_W-1:0] C_DEG_DIV = MIN_W'(DEG_DIV);
    localparam logic [R1_W-1:0]  C_R1      = R1_W'(R1);

    // minutes to 1e-7 degrees: min * 10^7 / (60 * 10^FRAC_DIGITS), reduced fraction
    localparam longint E7      = 10000000;
    localparam int     G2_EXP  = (2 + FRAC_DIGITS < 7) ? 2 + FRAC_DIGITS : 7;
    localparam int     G5_EXP  = (1 + FRAC_DIGITS < 7) ? 1 + FRAC_DIGITS : 7;
    localparam longint GCD_MIN = ipow(2, G2_EXP) * ipow(5, G5_EXP);
    localparam longint MIN_NUM = E7 / GCD_MIN;
    localparam longint MIN_DEN = 60 * pow10(FRAC_DIGITS) / GCD_MIN;
    localparam longint X_MAX   = (DEG_DIV - 1) * MIN_NUM;
    localparam int     X_W     = $clog2(X_MAX + 1);
    localparam int     Q_W     = $clog2(X_MAX / MIN_DEN + 1);
    localparam int     K2      = X_W;
    localparam longint R2      = (longint'(1) << K2) / MIN_DEN;
    localparam int     R2_W    = $clog2(R2 + 1);
    localparam int     M2_W    = X_W + R2_W;

    localparam logic [X_W-1:0]   C_MIN_NUM = X_W'(MIN_NUM);
    localparam logic [X_W-1:0]   C_MIN_DEN = X_W'(MIN_DEN);
    localparam logic [R2_W-1:0]  C_R2      = R2_W'(R2);
    localparam logic [MAG_W-1:0] C_E7      = MAG_W'(E7);

    // per-transaction sideband that rides along the conversion pipe
    typedef struct packed {
        logic       lat_neg;
        logic       lon_neg;
        logic [7:0] mode;
    } t_conv_side;

    // 10^(FRAC_DIGITS - frac): pads a short fraction to full length
    function automatic logic [SCALE_W-1:0] frac_scale(input logic [FRAC_W-1:0] frac);
        logic [SCALE_W-1:0] s;
        s = '0;
        for (int i = 0; i <= FRAC_DIGITS; i++) begin
            if (frac == FRAC_W'(i)) begin
                s = SCALE_W'(pow10(FRAC_DIGITS - i));
            end
        end
        return s;
    endfunction

    // padding overflows the limit exactly when acc >= 10^(5 + frac)
    function automatic logic [THR_W-1:0] frac_limit(input logic [FRAC_W-1:0] frac);
        logic [THR_W-1:0] t;
        t = '0;
        for (int i = 0; i <= FRAC_DIGITS; i++) begin
            if (frac == FRAC_W'(i)) begin
                t = THR_W'(pow10(5 + i));
            end
        end
        return t;
    endfunction

endpackage

### rtl/ngll_conv.sv
// pipelined ddmm.mmmmm to signed degrees e7 conversion for latitude and longitude
module ngll_conv import ngll_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [RAW_W-1:0]        i_lat_raw,
    input  logic [RAW_W-1:0]        i_lon_raw,
    input  t_conv_side              i_side,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_lat_e7,
    output logic signed [OUT_W-1:0] o_lon_e7,
    output logic [7:0]              o_mode
);

    localparam int NSTG = 8;

    logic [NSTG:1] r_vld;
    logic [NSTG:1] en;
    t_conv_side    r_side [NSTG:1];

    logic [RAW_W-1:0] raw_in [2];
    logic [OUT_W-1:0] out_e7 [2];

    assign raw_in[0] = i_lat_raw;
    assign raw_in[1] = i_lon_raw;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        en[NSTG] = !r_vld[NSTG] || i_out_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_side[1] <= i_side;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic [RAW_W-1:0] r1_raw, r2_raw, r2_prod;
        logic [DEG_W-1:0] r1_q, r2_q, r3_deg;
        logic [MIN_W-1:0] r3_min;
        logic [X_W-1:0]   r4_x, r5_x, r6_x, r6_prod;
        logic [Q_W-1:0]   r5_q, r6_q;
        logic [MAG_W-1:0] r4_dege7, r5_dege7, r6_dege7, r7_mag;
        logic [OUT_W-1:0] r8_out;

        logic [M1_W-1:0]  m1;
        logic [RAW_W-1:0] diff;
        logic             corr1;
        logic [M2_W-1:0]  m2;
        logic [X_W-1:0]   rem;
        logic             corr2;
        logic             neg;
        logic [OUT_W-1:0] mag_ext;

        always_comb begin
            m1      = M1_W'(raw_in[g]) * M1_W'(C_R1);
            diff    = r2_raw - r2_prod;
            corr1   = diff >= RAW_W'(C_DEG_DIV);
            m2      = M2_W'(r4_x) * M2_W'(C_R2);
            rem     = r6_x - r6_prod;
            corr2   = rem >= C_MIN_DEN;
            neg     = (g == 0) ? r_side[NSTG-1].lat_neg : r_side[NSTG-1].lon_neg;
            mag_ext = {1'b0, r7_mag};
        end

        always_ff @(posedge i_clk) begin
            // estimate degrees, may be one low
            if (en[1]) begin
                r1_raw <= raw_in[g];
                r1_q   <= DEG_W'(m1 >> K1);
            end
            if (en[2]) begin
                r2_raw  <= r1_raw;
                r2_q    <= r1_q;
                r2_prod <= RAW_W'(r1_q) * RAW_W'(C_DEG_DIV);
            end
            // fix up the estimate, leaves degrees and scaled minutes
            if (en[3]) begin
                r3_deg <= r2_q + DEG_W'(corr1);
                r3_min <= corr1 ? MIN_W'(diff - RAW_W'(C_DEG_DIV)) : MIN_W'(diff);
            end
            if (en[4]) begin
                r4_x     <= X_W'(r3_min) * C_MIN_NUM;
                r4_dege7 <= MAG_W'(r3_deg) * C_E7;
            end
            if (en[5]) begin
                r5_x     <= r4_x;
                r5_q     <= Q_W'(m2 >> K2);
                r5_dege7 <= r4_dege7;
            end
            if (en[6]) begin
                r6_x     <= r5_x;
                r6_q     <= r5_q;
                r6_prod  <= X_W'(r5_q) * C_MIN_DEN;
                r6_dege7 <= r5_dege7;
            end
            if (en[7]) begin
                r7_mag <= r6_dege7 + MAG_W'(r6_q + Q_W'(corr2));
            end
            if (en[8]) begin
                r8_out <= neg ? (~mag_ext + OUT_W'(1)) : mag_ext;
            end
        end

        assign out_e7[g] = r8_out;
    end

    assign o_in_ready  = en[1];
    assign o_out_valid = r_vld[NSTG];
    assign o_lat_e7    = out_e7[0];
    assign o_lon_e7    = out_e7[1];
    assign o_mode      = r_side[NSTG].mode;

endmodule

### rtl/nmea_gll_position_parser.sv
// throughput: one received byte per cycle, back to back, as long as results are taken
// a line feed enters an 8-stage conversion pipe; input stalls only when all stages are full and the output is held
// reset: synchronous active-low, clears the line state and the pipe, require_gll_type = 1
// configuration port is always ready and takes effect at the next line feed
module nmea_gll_position_parser import ngll_pkg::*; #(
    parameter int MAX_LINE = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // received byte stream
    input  logic                    i_rx_valid,
    output logic                    o_rx_ready,
    input  logic [7:0]              i_rx_byte,
    // position results
    output logic                    o_pos_valid,
    input  logic                    i_pos_ready,
    output logic signed [OUT_W-1:0] o_latitude_e7,
    output logic signed [OUT_W-1:0] o_longitude_e7,
    output logic [7:0]              o_fix_mode,
    // configuration register write
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_require_gll_type
);

    localparam int LEN_W = $clog2(MAX_LINE + 1);

    // ascii characters of interest
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [23:0] GLL_TAIL = 24'h474C4C;

    localparam logic [4:0] CNT_MAX = 5'd31;
    localparam int         FP_W    = RAW_W + SCALE_W;

    // comma-separated fields of the sentence
    typedef enum logic [2:0] {
        FLD_NAME,
        FLD_LAT,
        FLD_LAT_DIR,
        FLD_LON,
        FLD_LON_DIR,
        FLD_TIME,
        FLD_STATUS,
        FLD_MODE
    } t_field;

    // line state
    logic [LEN_W-1:0]  r_len, n_len;
    t_field            r_field, n_field;
    logic [4:0]        r_cnt, n_cnt;
    logic [23:0]       r_tail, n_tail;
    logic [RAW_W-1:0]  r_lat_acc, n_lat_acc;
    logic [RAW_W-1:0]  r_lon_acc, n_lon_acc;
    logic              r_point, n_point;
    logic              r_stop, n_stop;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic              r_lat_s, n_lat_s;
    logic              r_lon_w, n_lon_w;
    logic              r_stat_a, n_stat_a;
    logic [7:0]        r_mode, n_mode;
    logic              r_reject, n_reject;
    logic              r_req_gll;

    logic              rx_acc;
    logic              is_lf;
    logic              is_skip;
    logic              is_digit;
    logic [7:0]        digit8;
    logic [4:0]        cnt_inc;
    logic [RAW_W-1:0]  cur_acc;
    logic [RAW_W-1:0]  num_acc;
    logic [RAW_W-1:0]  fin_acc;
    logic [FP_W-1:0]   fin_prod;
    logic              fin_sat;
    logic              acc_upd;
    logic              emit;

    logic              conv_ready;
    logic              conv_valid;
    t_conv_side        conv_side;

    assign rx_acc   = i_rx_valid && o_rx_ready;
    assign is_lf    = i_rx_byte == CH_LF;
    assign is_skip  = (i_rx_byte == CH_CR) || (i_rx_byte == CH_NUL);
    assign is_digit = (i_rx_byte >= CH_0) && (i_rx_byte <= CH_9);
    assign digit8   = i_rx_byte - CH_0;
    assign cnt_inc  = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 5'd1;

    // only one coordinate field is ever open at a time
    assign cur_acc = (r_field == FLD_LAT) ? r_lat_acc : r_lon_acc;

    // next digit: acc * 10 + d, saturating to all nines
    always_comb begin
        if (cur_acc >= C_DIGIT_SAT) begin
            num_acc = C_RAW_LIMIT;
        end else begin
            num_acc = RAW_W'({cur_acc, 3'b000}) + RAW_W'({cur_acc, 1'b0})
                    + RAW_W'(digit8[3:0]);
        end
    end

    // field close: pad missing fraction digits, saturating to all nines
    assign fin_prod = FP_W'(cur_acc) * FP_W'(frac_scale(r_frac));
    assign fin_sat  = {1'b0, cur_acc} >= frac_limit(r_frac);
    assign fin_acc  = fin_sat ? C_RAW_LIMIT : RAW_W'(fin_prod);

    // a finished line produces a result only if fully well-formed and active
    assign emit = !r_reject && (r_field == FLD_MODE) && (r_cnt != 5'd0) && r_stat_a
               && (!r_req_gll || (r_tail == GLL_TAIL));

    always_comb begin
        n_len     = r_len;
        n_field   = r_field;
        n_cnt     = r_cnt;
        n_tail    = r_tail;
        n_lat_acc = r_lat_acc;
        n_lon_acc = r_lon_acc;
        n_point   = r_point;
        n_stop    = r_stop;
        n_frac    = r_frac;
        n_lat_s   = r_lat_s;
        n_lon_w   = r_lon_w;
        n_stat_a  = r_stat_a;
        n_mode    = r_mode;
        n_reject  = r_reject;
        acc_upd   = 1'b0;

        if (rx_acc && !is_skip) begin
            if (is_lf) begin
                // every line feed starts a fresh line
                n_len     = '0;
                n_field   = FLD_NAME;
                n_cnt     = '0;
                n_tail    = '0;
                n_lat_acc = '0;
                n_lon_acc = '0;
                n_point   = 1'b0;
                n_stop    = 1'b0;
                n_frac    = '0;
                n_lat_s   = 1'b0;
                n_lon_w   = 1'b0;
                n_stat_a  = 1'b0;
                n_mode    = '0;
                n_reject  = 1'b0;
            end else if (r_len >= LEN_W'(MAX_LINE)) begin
                n_reject = 1'b1;
            end else begin
                n_len = r_len + LEN_W'(1);
                if (!r_reject) begin
                    if (r_len == '0) begin
                        if (i_rx_byte != CH_DOLLAR) begin
                            n_reject = 1'b1;
                        end
                    end else if (r_field == FLD_MODE) begin
                        // first byte after the seventh comma, whatever it is
                        if (r_cnt == 5'd0) begin
                            n_mode = i_rx_byte;
                            n_cnt  = 5'd1;
                        end
                    end else if (i_rx_byte == CH_COMMA) begin
                        case (r_field)
                            FLD_NAME: begin
                                if (r_cnt == 5'd0) begin
                                    n_reject = 1'b1;
                                end
                            end
                            FLD_LAT, FLD_LON, FLD_TIME: begin
                                if ((r_cnt == 5'd0) || (r_cnt > 5'(MAX_FIELD))) begin
                                    n_reject = 1'b1;
                                end
                                if (r_field == FLD_LAT) begin
                                    n_lat_acc = fin_acc;
                                end
                                if (r_field == FLD_LON) begin
                                    n_lon_acc = fin_acc;
                                end
                            end
                            default: begin
                                if (r_cnt != 5'd1) begin
                                    n_reject = 1'b1;
                                end
                            end
                        endcase
                        n_field = t_field'(r_field + 3'd1);
                        n_cnt   = '0;
                        n_point = 1'b0;
                        n_stop  = 1'b0;
                        n_frac  = '0;
                    end else begin
                        n_cnt = cnt_inc;
                        case (r_field)
                            FLD_NAME: begin
                                n_tail = {r_tail[15:0], i_rx_byte};
                            end
                            FLD_LAT, FLD_LON: begin
                                // digits until the first stop character
                                if (!r_stop) begin
                                    if (is_digit) begin
                                        if (!(r_point && (r_frac >= FRAC_W'(FRAC_DIGITS)))) begin
                                            acc_upd = 1'b1;
                                            if (r_point) begin
                                                n_frac = r_frac + FRAC_W'(1);
                                            end
                                        end
                                    end else if ((i_rx_byte == CH_POINT) && !r_point) begin
                                        n_point = 1'b1;
                                    end else begin
                                        n_stop = 1'b1;
                                    end
                                end
                                if (cnt_inc > 5'(MAX_FIELD)) begin
                                    n_reject = 1'b1;
                                end
                            end
                            FLD_TIME: begin
                                if (cnt_inc > 5'(MAX_FIELD)) begin
                                    n_reject = 1'b1;
                                end
                            end
                            FLD_LAT_DIR: begin
                                if (cnt_inc == 5'd1) begin
                                    n_lat_s = i_rx_byte == CH_S;
                                end
                                if (cnt_inc > 5'd1) begin
                                    n_reject = 1'b1;
                                end
                            end
                            FLD_LON_DIR: begin
                                if (cnt_inc == 5'd1) begin
                                    n_lon_w = i_rx_byte == CH_W;
                                end
                                if (cnt_inc > 5'd1) begin
                                    n_reject = 1'b1;
                                end
                            end
                            FLD_STATUS: begin
                                if (cnt_inc == 5'd1) begin
                                    n_stat_a = i_rx_byte == CH_A;
                                end
                                if (cnt_inc > 5'd1) begin
                                    n_reject = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (acc_upd) begin
                            if (r_field == FLD_LAT) begin
                                n_lat_acc = num_acc;
                            end else begin
                                n_lon_acc = num_acc;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_field   <= FLD_NAME;
            r_cnt     <= '0;
            r_tail    <= '0;
            r_lat_acc <= '0;
            r_lon_acc <= '0;
            r_point   <= 1'b0;
            r_stop    <= 1'b0;
            r_frac    <= '0;
            r_lat_s   <= 1'b0;
            r_lon_w   <= 1'b0;
            r_stat_a  <= 1'b0;
            r_mode    <= '0;
            r_reject  <= 1'b0;
            r_req_gll <= 1'b1;
        end else begin
            r_len     <= n_len;
            r_field   <= n_field;
            r_cnt     <= n_cnt;
            r_tail    <= n_tail;
            r_lat_acc <= n_lat_acc;
            r_lon_acc <= n_lon_acc;
            r_point   <= n_point;
            r_stop    <= n_stop;
            r_frac    <= n_frac;
            r_lat_s   <= n_lat_s;
            r_lon_w   <= n_lon_w;
            r_stat_a  <= n_stat_a;
            r_mode    <= n_mode;
            r_reject  <= n_reject;
            if (i_cfg_valid && o_cfg_ready) begin
                r_req_gll <= i_cfg_require_gll_type;
            end
        end
    end

    // hand the finished line to the conversion pipe on its line feed
    assign conv_valid        = rx_acc && is_lf && emit;
    assign conv_side.lat_neg = r_lat_s;
    assign conv_side.lon_neg = r_lon_w;
    assign conv_side.mode    = r_mode;

    ngll_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (conv_valid),
        .o_in_ready  (conv_ready),
        .i_lat_raw   (r_lat_acc),
        .i_lon_raw   (r_lon_acc),
        .i_side      (conv_side),
        .o_out_valid (o_pos_valid),
        .i_out_ready (i_pos_ready),
        .o_lat_e7    (o_latitude_e7),
        .o_lon_e7    (o_longitude_e7),
        .o_mode      (o_fix_mode)
    );

    // bytes are taken whenever the pipe has room for a possible line feed
    assign o_rx_ready  = conv_ready;
    assign o_cfg_ready = 1'b1;

endmodule

### rtl/ngll_checker.sv
// port-level checks of the gll position parser and their bind
module ngll_checker import ngll_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_rx_ready,
    input logic                    o_pos_valid,
    input logic                    i_pos_ready,
    input logic signed [OUT_W-1:0] o_latitude_e7,
    input logic signed [OUT_W-1:0] o_longitude_e7,
    input logic [7:0]              o_fix_mode
);

    localparam logic signed [OUT_W-1:0] E7_MAX = 35'sd10006666665;
    localparam logic signed [OUT_W-1:0] E7_MIN = -35'sd10006666665;

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pos_valid && !i_pos_ready |=> o_pos_valid && $stable(o_latitude_e7)
            && $stable(o_longitude_e7) && $stable(o_fix_mode))
        else $error("result changed while stalled");

    // input stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> o_pos_valid && !i_pos_ready)
        else $error("input stalled without a blocked result");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pos_valid)
        else $error("result valid after reset");

    // converted coordinates stay within the ddmm range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pos_valid |-> (o_latitude_e7 <= E7_MAX) && (o_latitude_e7 >= E7_MIN)
            && (o_longitude_e7 <= E7_MAX) && (o_longitude_e7 >= E7_MIN))
        else $error("coordinate out of range");

endmodule

bind nmea_gll_position_parser ngll_checker u_ngll_checker (.*);

### tb/ngll_position_checker.sv
// character codes shared by the testbench and the position checker that predicts and compares
`timescale 1ns / 1ps

package nmea_chars_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_X      = 8'h78;

endpackage

module ngll_position_checker import ngll_pkg::*, nmea_chars_pkg::*; #(
    parameter int LINE_MAX = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rx_valid,
    input  logic                    i_rx_ready,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_pos_valid,
    input  logic                    i_pos_ready,
    input  logic signed [OUT_W-1:0] i_latitude_e7,
    input  logic signed [OUT_W-1:0] i_longitude_e7,
    input  logic [7:0]              i_fix_mode,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic                    i_cfg_require_gll_type,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_fixes_due,
    output int                      o_fixes_checked
);

    localparam int                FIELD_MAX = 15;
    localparam int                FRAC_KEEP = 5;
    localparam logic [63:0]       RAW_MAX   = 64'd9999999999;
    localparam logic [63:0]       DEG_UNIT  = 64'd10000000;
    localparam logic [63:0]       MIN_UNIT  = 64'd6000000;
    localparam logic [63:0]       E7        = 64'd10000000;
    localparam logic [23:0]       GLL_NAME  = 24'h474C4C;

    typedef enum logic [3:0] {
        F_NAME, F_LAT, F_LAT_DIR, F_LON, F_LON_DIR, F_TIME, F_STATUS, F_MODE
    } gll_field_e;

    typedef struct {
        logic signed [OUT_W-1:0] lat;
        logic signed [OUT_W-1:0] lon;
        logic [7:0]              mode;
    } fix_t;

    // sentence state, rebuilt from the accepted bytes
    logic        gll_only;
    logic [7:0]  line_len;
    gll_field_e  fld;
    logic [4:0]  fcnt;
    logic [23:0] name_tail;
    logic [33:0] lat_raw;
    logic [33:0] lon_raw;
    logic        point_seen;
    logic        num_stopped;
    logic [3:0]  frac_cnt;
    logic [7:0]  lat_dir;
    logic [7:0]  lon_dir;
    logic [7:0]  status_ch;
    logic [7:0]  mode_ch;
    logic        reject;

    fix_t fixes_q[$];
    int   errors;
    int   fixes_due;
    int   fixes_checked;

    task automatic clear_line();
        line_len    = '0;
        fld         = F_NAME;
        fcnt        = '0;
        name_tail   = '0;
        lat_raw     = '0;
        lon_raw     = '0;
        point_seen  = 1'b0;
        num_stopped = 1'b0;
        frac_cnt    = '0;
        lat_dir     = '0;
        lon_dir     = '0;
        status_ch   = '0;
        mode_ch     = '0;
        reject      = 1'b0;
    endtask

    // ddmm.mmmmm text into a fixed-point value, saturating at all nines
    task automatic digit_step(inout logic [33:0] acc, input logic [7:0] b);
        logic [63:0] t;
        if (num_stopped) return;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            if (point_seen && frac_cnt >= FRAC_KEEP) return;
            t = 64'(acc) * 64'd10 + 64'(b - CH_ZERO);
            if (t > RAW_MAX) t = RAW_MAX;
            acc = t[33:0];
            if (point_seen) frac_cnt = frac_cnt + 4'd1;
        end else if (b == CH_POINT && !point_seen) begin
            point_seen = 1'b1;
        end else begin
            num_stopped = 1'b1;
        end
    endtask

    task automatic pad_fraction(inout logic [33:0] acc);
        logic [63:0] t;
        int          kept;
        kept = (frac_cnt > FRAC_KEEP) ? FRAC_KEEP : int'(frac_cnt);
        t = 64'(acc);
        for (int i = kept; i < FRAC_KEEP; i++) t = t * 64'd10;
        if (t > RAW_MAX) t = RAW_MAX;
        acc = t[33:0];
    endtask

    task automatic close_field();
        case (fld)
            F_NAME: begin
                if (fcnt == 0) reject = 1'b1;
            end
            F_LAT, F_LON, F_TIME: begin
                if (fcnt == 0 || fcnt > FIELD_MAX) reject = 1'b1;
                if (fld == F_LAT) pad_fraction(lat_raw);
                if (fld == F_LON) pad_fraction(lon_raw);
            end
            default: begin
                if (fcnt != 1) reject = 1'b1;
            end
        endcase
        fld         = gll_field_e'(fld + 4'd1);
        fcnt        = '0;
        point_seen  = 1'b0;
        num_stopped = 1'b0;
        frac_cnt    = '0;
    endtask

    task automatic store_byte(input logic [7:0] b);
        if (line_len >= LINE_MAX) begin
            reject = 1'b1;
            return;
        end
        line_len = line_len + 8'd1;
        if (reject) return;
        if (line_len == 8'd1) begin
            if (b != CH_DOLLAR) reject = 1'b1;
            return;
        end
        if (fld == F_MODE) begin
            if (fcnt == 0) begin
                mode_ch = b;
                fcnt    = 5'd1;
            end
            return;
        end
        if (b == CH_COMMA) begin
            close_field();
            return;
        end
        if (fcnt < 5'd31) fcnt = fcnt + 5'd1;
        case (fld)
            F_NAME:    name_tail = {name_tail[15:0], b};
            F_LAT:     digit_step(lat_raw, b);
            F_LON:     digit_step(lon_raw, b);
            F_LAT_DIR: if (fcnt == 5'd1) lat_dir = b;
            F_LON_DIR: if (fcnt == 5'd1) lon_dir = b;
            F_STATUS:  if (fcnt == 5'd1) status_ch = b;
            default:   ;
        endcase
        if ((fld == F_LAT || fld == F_LON || fld == F_TIME) && fcnt > FIELD_MAX)
            reject = 1'b1;
        if ((fld == F_LAT_DIR || fld == F_LON_DIR || fld == F_STATUS) && fcnt > 5'd1)
            reject = 1'b1;
    endtask

    // degrees plus truncated minutes / 60, then the sign
    function automatic logic signed [OUT_W-1:0] raw_to_e7(input logic [33:0] raw,
                                                          input logic neg);
        logic [63:0] r;
        logic [63:0] deg;
        logic [63:0] mins;
        logic [63:0] mag;
        r    = 64'(raw);
        deg  = r / DEG_UNIT;
        mins = r - deg * DEG_UNIT;
        mag  = deg * E7 + (mins * E7) / MIN_UNIT;
        if (neg) mag = -mag;
        return mag[OUT_W-1:0];
    endfunction

    task automatic take_byte(input logic [7:0] b);
        fix_t f;
        if (b == CH_CR || b == CH_NUL) return;
        if (b != CH_LF) begin
            store_byte(b);
            return;
        end
        if (!reject && fld == F_MODE && fcnt != 0 && status_ch == CH_A &&
            (!gll_only || name_tail == GLL_NAME)) begin
            f.lat  = raw_to_e7(lat_raw, lat_dir == CH_S);
            f.lon  = raw_to_e7(lon_raw, lon_dir == CH_W);
            f.mode = mode_ch;
            fixes_q.push_back(f);
            fixes_due++;
        end
        clear_line();
    endtask

    task automatic check_fix();
        fix_t f;
        if (fixes_q.size() == 0) begin
            $error("position result with no line waiting: lat %0d lon %0d mode %02h",
                   i_latitude_e7, i_longitude_e7, i_fix_mode);
            errors++;
            return;
        end
        f = fixes_q.pop_front();
        fixes_checked++;
        if (i_latitude_e7 !== f.lat) begin
            $error("latitude_e7 mismatch: expected %0d, actual %0d", f.lat, i_latitude_e7);
            errors++;
        end
        if (i_longitude_e7 !== f.lon) begin
            $error("longitude_e7 mismatch: expected %0d, actual %0d", f.lon, i_longitude_e7);
            errors++;
        end
        if (i_fix_mode !== f.mode) begin
            $error("fix_mode mismatch: expected %02h, actual %02h", f.mode, i_fix_mode);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gll_only = 1'b1;
            clear_line();
            fixes_q.delete();
            errors        = 0;
            fixes_due     = 0;
            fixes_checked = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) gll_only = i_cfg_require_gll_type;
            if (i_rx_valid && i_rx_ready) take_byte(i_rx_byte);
            if (i_pos_valid && i_pos_ready) check_fix();
        end
        o_errors        <= errors;
        o_pending       <= fixes_q.size();
        o_fixes_due     <= fixes_due;
        o_fixes_checked <= fixes_checked;
    end

endmodule

### tb/tb_nmea_gll_position_parser.sv
// testbench top: sentence stimulus, output stalls and verdict for the gll position parser
`timescale 1ns / 1ps

module tb_nmea_gll_position_parser;
    import ngll_pkg::*;
    import nmea_chars_pkg::*;

    localparam int LINE_MAX    = 128;
    // random part runs until both the byte count and the position count are reached
    localparam int BYTE_TARGET = 400;
    localparam int FIX_TARGET  = 4;
    // positions asked of the phase with the long hold, more than the 8 stages can keep
    localparam int HOLD_FIXES  = 9;
    localparam int PHASES      = 4;
    // long output hold, well beyond the 8 conversion stages
    localparam int LONG_HOLD   = 4000;
    // quiet cycles after the last result
    localparam int SETTLE      = 16;

    typedef enum int {
        DROP_BYTE, STRAY_BYTE, STRAY_COMMA, NO_DOLLAR, RUN_ON, WIDE_FIELD
    } damage_e;

    typedef enum int {
        ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, PERIODIC
    } rx_stall_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // byte stream into the parser
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte  = 8'h00;

    // position results out of the parser
    logic                    pos_valid;
    logic                    pos_ready = 1'b0;
    logic signed [OUT_W-1:0] lat_e7;
    logic signed [OUT_W-1:0] lon_e7;
    logic [7:0]              fix_mode;

    // type filter register
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_gll   = 1'b1;

    // from the checker
    int errors;
    int pending;
    int fixes_due;
    int fixes_checked;

    // sender bookkeeping
    logic [7:0] line_buf[$];
    int         burst_left  = 0;
    int         items_sent  = 0;
    int         lines_sent  = 0;
    int         holds_asked = 0;

    // receiver bookkeeping, owned by the stall process
    int        hold_left  = 0;
    int        holds_done = 0;
    rx_stall_e stall_kind = ALWAYS_READY;
    int        kind_left  = 0;

    always #5 clk = ~clk;

    nmea_gll_position_parser #(
        .MAX_LINE(LINE_MAX)
    ) uut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_rx_valid             (rx_valid),
        .o_rx_ready             (rx_ready),
        .i_rx_byte              (rx_byte),
        .o_pos_valid            (pos_valid),
        .i_pos_ready            (pos_ready),
        .o_latitude_e7          (lat_e7),
        .o_longitude_e7         (lon_e7),
        .o_fix_mode             (fix_mode),
        .i_cfg_valid            (cfg_valid),
        .o_cfg_ready            (cfg_ready),
        .i_cfg_require_gll_type (cfg_gll)
    );

    ngll_position_checker #(
        .LINE_MAX(LINE_MAX)
    ) pos_check (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_rx_valid             (rx_valid),
        .i_rx_ready             (rx_ready),
        .i_rx_byte              (rx_byte),
        .i_pos_valid            (pos_valid),
        .i_pos_ready            (pos_ready),
        .i_latitude_e7          (lat_e7),
        .i_longitude_e7         (lon_e7),
        .i_fix_mode             (fix_mode),
        .i_cfg_valid            (cfg_valid),
        .i_cfg_ready            (cfg_ready),
        .i_cfg_require_gll_type (cfg_gll),
        .o_errors               (errors),
        .o_pending              (pending),
        .o_fixes_due            (fixes_due),
        .o_fixes_checked        (fixes_checked)
    );

    // receiver: a stall pattern drawn at random for a random stretch, plus the long hold
    always @(posedge clk) begin
        if (!rst_n) begin
            pos_ready <= 1'b0;
            hold_left  = 0;
            kind_left  = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            pos_ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            // the sender keeps going while results pile up and the input stalls
            holds_done++;
            hold_left = LONG_HOLD;
            pos_ready <= 1'b0;
        end else begin
            if (kind_left == 0) begin
                stall_kind = rx_stall_e'($urandom_range(0, 3));
                kind_left  = $urandom_range(16, 256);
            end else begin
                kind_left--;
            end
            case (stall_kind)
                ALWAYS_READY:   pos_ready <= 1'b1;
                COIN_FLIP:      pos_ready <= 1'($urandom_range(0, 1));
                MOSTLY_STALLED: pos_ready <= ($urandom_range(0, 3) == 0);
                default:        pos_ready <= ((kind_left % 8) < 3);
            endcase
        end
    end

    // one byte transaction; the sender works in bursts with idle gaps between them
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // mostly short bursts, now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
        burst_left--;
        // carriage returns and zero bytes are dropped by the block
        if (b != CH_CR && b != CH_NUL) items_sent++;
    endtask

    task automatic send_line(input logic with_cr);
        if (with_cr) line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
        foreach (line_buf[i]) send_byte(line_buf[i]);
        line_buf.delete();
        lines_sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        put_text(s);
        send_line(1'b1);
    endtask

    function automatic logic [7:0] pick_char(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // coordinate text: whole digits, an optional fraction, sometimes a stray character
    task automatic put_number();
        int   whole;
        int   frac;
        logic point;
        whole = $urandom_range(0, 6);
        point = ($urandom_range(0, 3) != 0);
        frac  = point ? $urandom_range(0, 8) : 0;
        if (whole == 0 && !point) whole = 1;
        put_digits(whole);
        if (point) begin
            line_buf.push_back(CH_POINT);
            put_digits(frac);
        end
        if ($urandom_range(0, 11) == 0) begin
            line_buf.push_back(pick_char("-+ .E"));
            put_digits($urandom_range(0, 2));
        end
    endtask

    // a sentence without its line end; most carry a gll name and status A
    task automatic put_sentence();
        line_buf.push_back(CH_DOLLAR);
        if ($urandom_range(0, 99) < 85) begin
            line_buf.push_back(CH_A + 8'($urandom_range(0, 25)));
            line_buf.push_back(CH_A + 8'($urandom_range(0, 25)));
            put_text("GLL");
        end else begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(pick_char("GPRMCLAVTZ"));
        end
        line_buf.push_back(CH_COMMA);
        put_number();
        line_buf.push_back(CH_COMMA);
        line_buf.push_back(($urandom_range(0, 9) == 0) ? pick_char("SNXs") : pick_char("NS"));
        line_buf.push_back(CH_COMMA);
        put_number();
        line_buf.push_back(CH_COMMA);
        line_buf.push_back(($urandom_range(0, 9) == 0) ? pick_char("WEXw") : pick_char("EW"));
        line_buf.push_back(CH_COMMA);
        put_digits($urandom_range(1, 10));
        line_buf.push_back(CH_COMMA);
        line_buf.push_back(($urandom_range(0, 7) == 0) ? pick_char("VAXa") : CH_A);
        line_buf.push_back(CH_COMMA);
        // the mode may be any byte at all, even the high half of the code range
        line_buf.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : pick_char("ADENMS"));
        if ($urandom_range(0, 1) == 1) begin
            line_buf.push_back(CH_STAR);
            line_buf.push_back(pick_char("0123456789ABCDEF"));
            line_buf.push_back(pick_char("0123456789ABCDEF"));
        end
    endtask

    // break a sentence in one place
    task automatic damage_line();
        damage_e d;
        int      at;
        d  = damage_e'($urandom_range(0, 5));
        at = $urandom_range(0, line_buf.size() - 1);
        case (d)
            DROP_BYTE:   line_buf.delete(at);
            STRAY_BYTE:  line_buf.insert(at, 8'($urandom_range(0, 255)));
            STRAY_COMMA: line_buf[at] = CH_COMMA;
            NO_DOLLAR:   line_buf.delete(0);
            RUN_ON:      repeat ($urandom_range(80, 140)) line_buf.push_back(CH_X);
            default:     repeat (16) line_buf.insert(at, CH_ZERO + 8'($urandom_range(0, 9)));
        endcase
    endtask

    task automatic send_random_line();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) begin
            put_sentence();
        end else if (k < 85) begin
            put_sentence();
            damage_line();
        end else begin
            // raw noise, every byte value possible
            repeat ($urandom_range(1, 60)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        send_line($urandom_range(0, 9) != 0);
    endtask

    // wait until every predicted position has come out and the pipe has gone quiet
    task automatic settle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_gll_only(input logic v);
        cfg_valid <= 1'b1;
        cfg_gll   <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int start_items;
        int start_due;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sentences with the type filter on
        write_gll_only(1'b1);
        send_text("$GPGLL,4916.45,N,12311.12,W,225444,A,A");
        send_text("$GNGLL,9959.99999,S,17959.99999,E,0,A,D");
        // saturation of both coordinates
        send_text("$GPGLL,999999,N,99999999.999999,W,1,A,N");
        // zero and a bare fraction
        send_text("$GPGLL,0,N,.5,E,1,A,A");
        // fraction digits past five are dropped
        send_text("$GPGLL,4807.0381234,S,01131.00099999,E,123519,A,A");
        // signs and other characters stop the number
        send_text("$GPGLL,48-07,S,+123.4,W,1,A,A");
        send_text("$GPGLL,12.3.4,N,1.2a3,E,1,A,A");
        // longest numeric field and one character over it
        send_text("$GPGLL,123456789012345,N,.,E,1,A,A");
        send_text("$GPGLL,1234567890123456,N,1,E,1,A,A");
        // status not A
        send_text("$GPGLL,4916.45,N,12311.12,W,225444,V,A");
        // missing dollar and the field size rules
        send_text("GPGLL,4916.45,N,12311.12,W,225444,A,A");
        send_text("$,4916.45,N,12311.12,W,225444,A,A");
        send_text("$GPGLL,,N,1,E,1,A,A");
        send_text("$GPGLL,1,NN,1,E,1,A,A");
        send_text("$GPGLL,1,N,1,E,,A,A");
        // no mode field, an empty mode field, and a comma as the mode
        send_text("$GPGLL,1,N,1,E,1,A");
        send_text("$GPGLL,1,N,1,E,1,A,");
        send_text("$GPGLL,1,N,1,E,1,A,,*4C");
        // wrong sentence type while the filter is on
        send_text("$GPRMC,1,N,1,E,1,A,A");
        // carriage return and zero byte in the middle of a sentence, bare line feed
        put_text("$GPGLL,5130");
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_NUL);
        put_text(".5,N,00007.5,W,1,A,A");
        send_line(1'b0);
        // exactly the line limit, then far over it
        put_text("$GPGLL,1,N,1,E,1,A,A");
        repeat (LINE_MAX - 20) line_buf.push_back(CH_X);
        send_line(1'b1);
        put_text("$GPGLL,4916.45,N,12311.12,W,225444,A,A*");
        repeat (100) line_buf.push_back(CH_X);
        send_line(1'b1);
        // mode byte with the top bit set
        put_text("$GPGLL,1,N,1,E,1,A,");
        line_buf.push_back(8'hFF);
        send_line(1'b1);
        settle();

        // filter off: any name goes through
        write_gll_only(1'b0);
        send_text("$GPRMC,3723.2475,N,12158.3416,W,1,A,A");
        send_text("$X,1,S,1,W,1,A,E");
        send_text("$GPGLL,4916.45,S,12311.12,E,225444,A,A");
        settle();

        // random phases, filter alternating; the long output hold lands in the third one
        for (int phase = 0; phase < PHASES; phase++) begin
            write_gll_only(phase % 2 == 0);
            if (phase == 2) holds_asked <= holds_asked + 1;
            start_items = items_sent;
            start_due   = fixes_due;
            while (items_sent - start_items < BYTE_TARGET / PHASES ||
                   fixes_due - start_due < ((phase == 2) ? HOLD_FIXES
                                                         : FIX_TARGET / PHASES)) begin
                send_random_line();
            end
            settle();
        end

        $display("summary: %0d bytes in %0d lines, %0d positions checked",
                 items_sent, lines_sent, fixes_checked);
        $display("summary: type filter on and off, random output stalls, one %0d-cycle hold",
                 LONG_HOLD);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #3ms;
        $display("tb: failure");
        $finish;
    end

endmodule
